>>> src/ffck_pkg.sv
// Shared types, constants and key table for the calculator keypad.
package ffck_pkg;

    localparam int unsigned CLICK_W = 10;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CNT_W   = 4;

    localparam logic [9:0] CELL_W  = 10'd52;
    localparam logic [9:0] CELL_H  = 10'd42;
    localparam logic [9:0] GRID_X0 = 10'd5;
    localparam logic [9:0] GRID_Y0 = 10'd80;
    localparam logic [9:0] GRID_X1 = 10'd215;
    localparam logic [9:0] GRID_Y1 = 10'd290;
    localparam logic [4:0] KEY_CNT = 5'd20;

    // Exponent of the highest power of ten that fits in 32 bits unsigned
    localparam logic [3:0] LEN_LAST = 4'd9;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        KEY_NOP   = 3'd0,
        KEY_DIGIT = 3'd1,
        KEY_OPER  = 3'd2,
        KEY_EQ    = 3'd3,
        KEY_CLR   = 3'd4
    } key_kind_t;

    typedef struct packed {
        logic      hit;
        key_kind_t kind;
        logic [3:0] digit;
        op_t       op;
    } key_t;

    typedef struct packed {
        logic              start;
        op_t               op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
        logic [CNT_W-1:0]  length;
    } alu_rsp_t;

    function automatic logic [DATA_W-1:0] pow10(input logic [3:0] k);
        logic [DATA_W-1:0] p;
        unique case (k)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = '1;
        endcase
        return p;
    endfunction

    function automatic key_t key_lookup(input logic [4:0] idx);
        key_t k;
        k = '{hit: 1'b1, kind: KEY_NOP, digit: 4'd0, op: OP_NONE};
        unique case (idx)
            5'd0:  begin k.kind = KEY_DIGIT; k.digit = 4'd7; end
            5'd1:  begin k.kind = KEY_DIGIT; k.digit = 4'd8; end
            5'd2:  begin k.kind = KEY_DIGIT; k.digit = 4'd9; end
            5'd3:  begin k.kind = KEY_OPER;  k.op = OP_DIV; end
            5'd4:  begin k.kind = KEY_DIGIT; k.digit = 4'd4; end
            5'd5:  begin k.kind = KEY_DIGIT; k.digit = 4'd5; end
            5'd6:  begin k.kind = KEY_DIGIT; k.digit = 4'd6; end
            5'd7:  begin k.kind = KEY_OPER;  k.op = OP_MUL; end
            5'd8:  begin k.kind = KEY_DIGIT; k.digit = 4'd1; end
            5'd9:  begin k.kind = KEY_DIGIT; k.digit = 4'd2; end
            5'd10: begin k.kind = KEY_DIGIT; k.digit = 4'd3; end
            5'd11: begin k.kind = KEY_OPER;  k.op = OP_SUB; end
            5'd12: begin k.kind = KEY_DIGIT; k.digit = 4'd0; end
            5'd13: k.kind = KEY_NOP;
            5'd14: k.kind = KEY_EQ;
            5'd15: begin k.kind = KEY_OPER;  k.op = OP_ADD; end
            5'd16: k.kind = KEY_CLR;
            5'd17, 5'd18, 5'd19: k.kind = KEY_NOP;
            default: k.hit = 1'b0;
        endcase
        return k;
    endfunction

endpackage

>>> src/ffck_if.sv
// Valid/ready channel interfaces for click items and display items.
interface ffck_click_if;
    logic                         valid;
    logic                         ready;
    logic [ffck_pkg::CLICK_W-1:0] click_x;
    logic [ffck_pkg::CLICK_W-1:0] click_y;

    modport source (output valid, output click_x, output click_y, input ready);
    modport sink   (input valid, input click_x, input click_y, output ready);
endinterface

interface ffck_disp_if;
    logic                        valid;
    logic                        ready;
    logic                        key_hit;
    logic [ffck_pkg::DATA_W-1:0] display_value;
    logic                        display_empty;

    modport source (output valid, output key_hit, output display_value,
                    output display_empty, input ready);
    modport sink   (input valid, input key_hit, input display_value,
                    input display_empty, output ready);
endinterface

>>> src/ffck_keymap.sv
// Click position to key decode over the 4-by-5 cell grid.
module ffck_keymap (
    input  logic [ffck_pkg::CLICK_W-1:0] click_x,
    input  logic [ffck_pkg::CLICK_W-1:0] click_y,
    output ffck_pkg::key_t               key
);
    import ffck_pkg::*;

    logic       in_grid;
    logic [9:0] dx;
    logic [9:0] dy;
    logic [2:0] col;
    logic [2:0] row;
    logic [4:0] idx;

    assign in_grid = (click_x >= GRID_X0) && (click_x <= GRID_X1) &&
                     (click_y >= GRID_Y0) && (click_y <= GRID_Y1);
    assign dx = click_x - GRID_X0;
    assign dy = click_y - GRID_Y0;

    always_comb
    begin
        priority if (dx >= 10'(4 * CELL_W)) col = 3'd4;
        else if (dx >= 10'(3 * CELL_W))     col = 3'd3;
        else if (dx >= 10'(2 * CELL_W))     col = 3'd2;
        else if (dx >= CELL_W)              col = 3'd1;
        else                                col = 3'd0;

        priority if (dy >= 10'(5 * CELL_H)) row = 3'd5;
        else if (dy >= 10'(4 * CELL_H))     row = 3'd4;
        else if (dy >= 10'(3 * CELL_H))     row = 3'd3;
        else if (dy >= 10'(2 * CELL_H))     row = 3'd2;
        else if (dy >= CELL_H)              row = 3'd1;
        else                                row = 3'd0;
    end

    assign idx = {row, 2'b00} + {2'b00, col};

    always_comb
    begin
        key = key_lookup(idx);
        if (!in_grid || idx >= KEY_CNT)
        begin
            key.hit = 1'b0;
        end
    end

endmodule

>>> src/ffck_alu.sv
// Add, subtract, iterative shift-add multiply and shift-subtract divide, with decimal length count.
module ffck_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  ffck_pkg::alu_req_t req,
    output ffck_pkg::alu_rsp_t rsp
);
    import ffck_pkg::*;

    typedef enum logic [6:0] {
        U_IDLE  = 7'b0000001,
        U_MUL   = 7'b0000010,
        U_DIV   = 7'b0000100,
        U_DSIGN = 7'b0001000,
        U_LPREP = 7'b0010000,
        U_LEN   = 7'b0100000,
        U_DONE  = 7'b1000000
    } ustate_t;

    ustate_t           state_reg, state_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W:0]   acc_reg, acc_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  len_reg, len_next;

    logic [DATA_W-1:0] mul_sum;
    logic [DATA_W:0]   div_shift;
    logic [DATA_W:0]   div_diff;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;

    assign mag_a     = req.a[DATA_W-1] ? (~req.a + 1'b1) : req.a;
    assign mag_b     = req.b[DATA_W-1] ? (~req.b + 1'b1) : req.b;
    assign mul_sum   = acc_reg[DATA_W-1:0] + (b_reg[0] ? a_reg : '0);
    assign div_shift = {acc_reg[DATA_W-1:0], b_reg[DATA_W-1]};
    assign div_diff  = div_shift - {1'b0, a_reg};

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        len_next   = len_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    cnt_next = '0;
                    acc_next = '0;
                    unique case (req.op)
                        OP_ADD:
                        begin
                            res_next   = req.a + req.b;
                            state_next = U_LPREP;
                        end
                        OP_SUB:
                        begin
                            res_next   = req.a - req.b;
                            state_next = U_LPREP;
                        end
                        OP_MUL:
                        begin
                            a_next     = req.a;
                            b_next     = req.b;
                            state_next = U_MUL;
                        end
                        OP_DIV:
                        begin
                            if (req.b == '0)
                            begin
                                res_next   = '0;
                                state_next = U_LPREP;
                            end
                            else
                            begin
                                a_next     = mag_b;
                                b_next     = mag_a;
                                neg_next   = req.a[DATA_W-1] ^ req.b[DATA_W-1];
                                state_next = U_DIV;
                            end
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = U_LPREP;
                        end
                    endcase
                end
            end
            U_MUL:
            begin
                acc_next = {1'b0, mul_sum};
                a_next   = {a_reg[DATA_W-2:0], 1'b0};
                b_next   = {1'b0, b_reg[DATA_W-1:1]};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DATA_W - 1))
                begin
                    res_next   = mul_sum;
                    state_next = U_LPREP;
                end
            end
            U_DIV:
            begin
                if (!div_diff[DATA_W])
                begin
                    acc_next = div_diff;
                    b_next   = {b_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = div_shift;
                    b_next   = {b_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DATA_W - 1))
                begin
                    state_next = U_DSIGN;
                end
            end
            U_DSIGN:
            begin
                res_next   = neg_reg ? (~b_reg + 1'b1) : b_reg;
                state_next = U_LPREP;
            end
            U_LPREP:
            begin
                acc_next   = {1'b0, res_reg[DATA_W-1] ? (~res_reg + 1'b1) : res_reg};
                len_next   = res_reg[DATA_W-1] ? 4'd2 : 4'd1;
                cnt_next   = 5'd1;
                state_next = U_LEN;
            end
            U_LEN:
            begin
                if (acc_reg[DATA_W-1:0] >= pow10(cnt_reg[3:0]))
                begin
                    len_next = len_reg + 4'd1;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[3:0] == LEN_LAST)
                begin
                    state_next = U_DONE;
                end
            end
            U_DONE:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        len_reg <= len_next;
    end

    assign rsp.done   = (state_reg == U_DONE);
    assign rsp.result = res_reg;
    assign rsp.length = len_reg;

endmodule

>>> src/four_function_calculator_keypad.sv
// Four-function integer calculator driven by click positions on a key grid.
// One click item is taken at a time, and one display item comes back per click.
// Digit, operator, clear and blank keys, missed clicks and an equals that has
// nothing to apply go from the decode state to the put state; an equals with an
// operation pending first waits for the arithmetic unit. The put state loads the
// display item once any earlier item is taken, and the next click can be taken
// in the cycle after it is loaded. The arithmetic unit runs a 32-step shift-add
// or shift-subtract loop for multiply and divide, then a nine-step compare against
// powers of ten to count the decimal length of the result. The display output is
// registered, so a waiting result holds while the next click is decoded.
module four_function_calculator_keypad #(
    parameter int unsigned MAX_DIGITS = 15
) (
    input  logic         clk,
    input  logic         rst_n,
    ffck_click_if.sink   click,
    ffck_disp_if.source  disp
);
    import ffck_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_KEY  = 4'b0010,
        T_WAIT = 4'b0100,
        T_PUT  = 4'b1000
    } tstate_t;

    tstate_t              state_reg, state_next;
    logic [CLICK_W-1:0]   x_reg, y_reg;
    logic [DATA_W-1:0]    shown_reg, shown_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [DATA_W-1:0]    first_reg, first_next;
    op_t                  pend_reg, pend_next;
    logic                 fresh_reg, fresh_next;
    logic                 hit_reg, hit_next;
    logic                 ovalid_reg, ovalid_next;
    logic                 ohit_reg;
    logic [DATA_W-1:0]    oval_reg;
    logic                 oempty_reg;

    key_t                 key;
    alu_req_t             req;
    alu_rsp_t             rsp;
    logic [DATA_W-1:0]    base_val;
    logic [CNT_W-1:0]     base_cnt;
    logic                 load_out;

    ffck_keymap u_keymap (
        .click_x (x_reg),
        .click_y (y_reg),
        .key     (key)
    );

    ffck_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign base_val = fresh_reg ? '0 : shown_reg;
    assign base_cnt = fresh_reg ? '0 : count_reg;
    assign load_out = (state_reg == T_PUT) && (!ovalid_reg || disp.ready);

    always_comb
    begin
        state_next = state_reg;
        shown_next = shown_reg;
        count_next = count_reg;
        first_next = first_reg;
        pend_next  = pend_reg;
        fresh_next = fresh_reg;
        hit_next   = hit_reg;
        req        = '{start: 1'b0, op: pend_reg, a: first_reg, b: shown_reg};
        unique case (state_reg)
            T_IDLE:
            begin
                if (click.valid)
                begin
                    state_next = T_KEY;
                end
            end
            T_KEY:
            begin
                hit_next   = key.hit;
                state_next = T_PUT;
                if (key.hit)
                begin
                    unique case (key.kind)
                        KEY_DIGIT:
                        begin
                            fresh_next = 1'b0;
                            shown_next = base_val;
                            count_next = base_cnt;
                            if (base_cnt < MAX_CNT)
                            begin
                                shown_next = {base_val[DATA_W-4:0], 3'b000} +
                                             {base_val[DATA_W-2:0], 1'b0} +
                                             {{(DATA_W-4){1'b0}}, key.digit};
                                count_next = base_cnt + 4'd1;
                            end
                        end
                        KEY_CLR:
                        begin
                            shown_next = '0;
                            count_next = '0;
                            first_next = '0;
                            pend_next  = OP_NONE;
                            fresh_next = 1'b1;
                        end
                        KEY_OPER:
                        begin
                            if (count_reg != '0)
                            begin
                                first_next = shown_reg;
                                pend_next  = key.op;
                                fresh_next = 1'b1;
                            end
                        end
                        KEY_EQ:
                        begin
                            if (count_reg != '0 && pend_reg != OP_NONE)
                            begin
                                req.start  = 1'b1;
                                state_next = T_WAIT;
                            end
                        end
                        KEY_NOP:
                        begin
                            state_next = T_PUT;
                        end
                        default:
                        begin
                            state_next = T_PUT;
                        end
                    endcase
                end
            end
            T_WAIT:
            begin
                if (rsp.done)
                begin
                    shown_next = rsp.result;
                    count_next = rsp.length;
                    pend_next  = OP_NONE;
                    fresh_next = 1'b1;
                    state_next = T_PUT;
                end
            end
            T_PUT:
            begin
                if (load_out)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (disp.ready)
        begin
            ovalid_next = 1'b0;
        end
        if (load_out)
        begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            shown_reg  <= '0;
            count_reg  <= '0;
            first_reg  <= '0;
            pend_reg   <= OP_NONE;
            fresh_reg  <= 1'b1;
            hit_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            shown_reg  <= shown_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
            pend_reg   <= pend_next;
            fresh_reg  <= fresh_next;
            hit_reg    <= hit_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (click.valid && click.ready)
        begin
            x_reg <= click.click_x;
            y_reg <= click.click_y;
        end
        if (load_out)
        begin
            ohit_reg   <= hit_reg;
            oval_reg   <= (count_reg != '0) ? shown_reg : '0;
            oempty_reg <= (count_reg == '0);
        end
    end

    assign click.ready        = (state_reg == T_IDLE);
    assign disp.valid         = ovalid_reg;
    assign disp.key_hit       = ohit_reg;
    assign disp.display_value = oval_reg;
    assign disp.display_empty = oempty_reg;

endmodule

>>> src/ffck_checker.sv
// Port-level assertions for the calculator keypad, bound to the top level.
module ffck_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        key_hit,
    input logic [ffck_pkg::DATA_W-1:0] display_value,
    input logic                        display_empty
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("display item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(display_value) &&
            $stable(display_empty) && $stable(key_hit))
        else $error("display payload changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && display_empty |-> display_value == '0)
        else $error("empty display shows a nonzero value");

    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second click taken while one is in progress");

endmodule

bind four_function_calculator_keypad ffck_checker u_ffck_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (click.valid),
    .in_ready      (click.ready),
    .out_valid     (disp.valid),
    .out_ready     (disp.ready),
    .key_hit       (disp.key_hit),
    .display_value (disp.display_value),
    .display_empty (disp.display_empty)
);
